// File: src/gtl_pkg.sv
// shared constants, rom contents and helpers for the gregorian to lunar date converter
`default_nettype none

package gtl_pkg;

    localparam int BASE_YEAR        = 1901;
    localparam int TABLE_YEARS_MAX  = 150;
    localparam int DAY_OFFSET       = 49;
    localparam int GREG_YEAR_LEN    = 365;
    localparam int GREG_LEAP_LEN    = 366;
    localparam int LUNAR_SHORT_LEN  = 29;
    localparam int LUNAR_LONG_LEN   = 30;
    localparam int LUNAR_LEN12      = 12 * LUNAR_SHORT_LEN;
    localparam int LUNAR_LEN13      = 13 * LUNAR_SHORT_LEN;
    localparam int FIRST_LUNAR_DAY  = 18;
    localparam int BASE_MOD100      = BASE_YEAR % 100;
    localparam int BASE_MOD400      = BASE_YEAR % 400;

    localparam logic [15:0] MONTHS12_SEL = 16'hfff0;
    localparam logic [15:0] MONTHS13_SEL = 16'hfff8;

    localparam int IN_W  = 24;
    localparam int OUT_W = 24;

    // month-length masks, bit 15 is the first month, set means 30 days
    localparam logic [15:0] MASK_ROM [TABLE_YEARS_MAX] = '{
        16'h4ae0, 16'ha570, 16'h5268, 16'hd260, 16'hd950, 16'h6aa8, 16'h56a0, 16'h9ad0,
        16'h4ae8, 16'h4ae0, 16'ha4d8, 16'ha4d0, 16'hd250, 16'hd548, 16'hb550, 16'h56a0,
        16'h96d0, 16'h95b0, 16'h49b8, 16'h49b0, 16'ha4b0, 16'hb258, 16'h6a50, 16'h6d40,
        16'hada8, 16'h2b60, 16'h9570, 16'h4978, 16'h4970, 16'h64b0, 16'hd4a0, 16'hea50,
        16'h6d48, 16'h5ad0, 16'h2b60, 16'h9370, 16'h92e0, 16'hc968, 16'hc950, 16'hd4a0,
        16'hda50, 16'hb550, 16'h56a0, 16'haad8, 16'h25d0, 16'h92d0, 16'hc958, 16'ha950,
        16'hb4a8, 16'h6ca0, 16'hb550, 16'h55a8, 16'h4da0, 16'ha5b0, 16'h52b8, 16'h52b0,
        16'ha950, 16'he950, 16'h6aa0, 16'had50, 16'hab50, 16'h4b60, 16'ha570, 16'ha570,
        16'h5260, 16'he930, 16'hd950, 16'h5aa8, 16'h56a0, 16'h96d0, 16'h4ae8, 16'h4ad0,
        16'ha4d0, 16'hd268, 16'hd250, 16'hd528, 16'hb540, 16'hb6a0, 16'h96d0, 16'h95b0,
        16'h49b0, 16'ha4b8, 16'ha4b0, 16'hb258, 16'h6a50, 16'h6d40, 16'hada0, 16'hab60,
        16'h9370, 16'h4978, 16'h4970, 16'h64b0, 16'h6a50, 16'hea50, 16'h6b28, 16'h5ac0,
        16'hab60, 16'h9368, 16'h92e0, 16'hc960, 16'hd4a8, 16'hd4a0, 16'hda50, 16'h5aa8,
        16'h56a0, 16'haad8, 16'h25d0, 16'h92d0, 16'hc958, 16'ha950, 16'hb4a0, 16'hb550,
        16'hb550, 16'h55a8, 16'h4ba0, 16'ha5b0, 16'h52b8, 16'h52b0, 16'ha930, 16'h74a8,
        16'h6aa0, 16'had50, 16'h4da8, 16'h4b60, 16'h9570, 16'ha4e0, 16'hd260, 16'he930,
        16'hd530, 16'h5aa0, 16'h6b50, 16'h96d0, 16'h4ae8, 16'h4ad0, 16'ha4d0, 16'hd258,
        16'hd250, 16'hd520, 16'hdaa0, 16'hb5a0, 16'h56d0, 16'h4ad8, 16'h49b0, 16'ha4b8,
        16'ha4b0, 16'haa50, 16'hb528, 16'h6d20, 16'hada0, 16'h55b0
    };

    // leap month numbers, two years a byte: high nibble odd year, low nibble even year
    localparam logic [7:0] LEAP_ROM [TABLE_YEARS_MAX / 2] = '{
        8'h00, 8'h50, 8'h04, 8'h00, 8'h20, 8'h60, 8'h05, 8'h00, 8'h20, 8'h70,
        8'h05, 8'h00, 8'h40, 8'h02, 8'h06, 8'h00, 8'h50, 8'h03, 8'h07, 8'h00,
        8'h60, 8'h04, 8'h00, 8'h20, 8'h70, 8'h05, 8'h00, 8'h30, 8'h80, 8'h06,
        8'h00, 8'h40, 8'h03, 8'h07, 8'h00, 8'h50, 8'h04, 8'h08, 8'h00, 8'h60,
        8'h04, 8'h0a, 8'h00, 8'h60, 8'h05, 8'h00, 8'h30, 8'h80, 8'h05, 8'h00,
        8'h40, 8'h02, 8'h07, 8'h00, 8'h50, 8'h04, 8'h09, 8'h00, 8'h60, 8'h04,
        8'h00, 8'h20, 8'h60, 8'h05, 8'h00, 8'h30, 8'hb0, 8'h06, 8'h00, 8'h50,
        8'h02, 8'h07, 8'h00, 8'h50, 8'h03
    };

    // gregorian month length in a common year
    function automatic logic [4:0] greg_month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:                       len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: src/gregorian_to_lunar_date.sv
// gregorian to chinese lunar date converter, top level
`default_nettype none

//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  gregorian date item
//  m_axis    out  m_axis_tvalid / m_axis_tready  lunar date item
//
//  one item at a time; the sequencer steps one gregorian year, one gregorian month,
//  one lunar year or one lunar month per cycle, the lunar steps through the rom read port
//  reset clears the sequencer and the output valid flag, no clearing pass is needed
//  a finished item waits in the output register while a new item is accepted;
//  a stalled m_axis holds the next result in the final state

module gregorian_to_lunar_date #(
    parameter int TABLE_YEARS = gtl_pkg::TABLE_YEARS_MAX
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // greg_year[11:0], greg_month[15:12], greg_day[20:16], zero fill
    input  wire logic [gtl_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // valid_res[0], lunar_year[12:1], lunar_month[16:13], lunar_day[21:17],
    // is_leap_month[22], zero fill
    output logic [gtl_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int IDX_W  = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;
    localparam int MASK_IDX_W = $clog2(gtl_pkg::TABLE_YEARS_MAX);
    localparam int LEAP_IDX_W = $clog2(gtl_pkg::TABLE_YEARS_MAX / 2);
    localparam int DAYS_W = $clog2(TABLE_YEARS * gtl_pkg::GREG_LEAP_LEN + 400);
    localparam logic [11:0] FIRST_YEAR = 12'(gtl_pkg::BASE_YEAR);
    localparam logic [11:0] LAST_YEAR  = 12'(gtl_pkg::BASE_YEAR + TABLE_YEARS - 1);
    localparam logic [IDX_W-1:0] LAST_OFF = IDX_W'(TABLE_YEARS - 1);

    typedef enum logic [2:0] {
        IDLE,
        GREG_YEAR,
        GREG_MONTH,
        LUNAR_YEAR,
        LUNAR_MONTH,
        FINISH
    } state_t;

    state_t state_reg, state_next;

    // captured input item
    logic [11:0] gy_reg, gy_next;
    logic [3:0]  gm_reg, gm_next;
    logic [4:0]  gd_reg, gd_next;

    // gregorian walk, with mod 100 and mod 400 counters for the leap rule
    logic [11:0] y_reg, y_next;
    logic [6:0]  c100_reg, c100_next;
    logic [8:0]  c400_reg, c400_next;
    logic [3:0]  mo_reg, mo_next;

    // day count, later the days left inside the lunar year or month
    logic [DAYS_W-1:0] days_reg, days_next;

    // lunar walk
    logic [IDX_W-1:0] off_reg, off_next;
    logic [3:0]       mon_reg, mon_next;
    logic             after_reg, after_next;

    // result held for the output register
    logic        res_valid_reg, res_valid_next;
    logic [11:0] res_year_reg, res_year_next;
    logic [3:0]  res_month_reg, res_month_next;
    logic [4:0]  res_day_reg, res_day_next;
    logic        res_leap_reg, res_leap_next;

    logic                     out_valid_reg, out_valid_next;
    logic [gtl_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // rom read registers, address is the next year offset
    logic [15:0] mask_q;
    logic [7:0]  leap_byte_q;

    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic        accept;
    logic        in_bad;
    logic        y_leap;
    logic [3:0]  leap_nib;
    logic        has_leap;
    logic [3:0]  long_cnt;
    logic [8:0]  year_len;
    logic [3:0]  bit_idx;
    logic [4:0]  mon_len;
    logic [3:0]  last_mon;
    logic [3:0]  prev_mon;
    logic [DAYS_W-1:0] greg_sum;
    logic [DAYS_W-1:0] year_len_w;
    logic [DAYS_W-1:0] mon_len_w;

    assign in_year  = s_axis_tdata[11:0];
    assign in_month = s_axis_tdata[15:12];
    assign in_day   = s_axis_tdata[20:16];

    assign s_axis_tready = (state_reg == IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // out of range years, dates before the first new year, a month of zero or above twelve, or a day of zero
    assign in_bad = (in_year < FIRST_YEAR) || (in_year > LAST_YEAR)
                 || ((in_year == FIRST_YEAR)
                     && ((in_month == 4'd1)
                         || ((in_month == 4'd2)
                             && (in_day <= 5'(gtl_pkg::FIRST_LUNAR_DAY)))))
                 || (in_month == 4'd0) || (in_month > 4'd12) || (in_day == 5'd0);

    assign y_leap = (y_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));

    // even offset is an odd year and takes the high nibble
    assign leap_nib = off_reg[0] ? leap_byte_q[3:0] : leap_byte_q[7:4];
    assign has_leap = (leap_nib != 4'd0);
    assign last_mon = has_leap ? 4'd13 : 4'd12;

    assign long_cnt = 4'($countones(mask_q & (has_leap ? gtl_pkg::MONTHS13_SEL
                                                      : gtl_pkg::MONTHS12_SEL)));
    assign year_len = (has_leap ? 9'(gtl_pkg::LUNAR_LEN13) : 9'(gtl_pkg::LUNAR_LEN12))
                    + 9'(long_cnt);
    assign year_len_w = DAYS_W'(year_len);

    // month number one maps to mask bit 15
    assign bit_idx   = 4'(5'd16 - {1'b0, mon_reg});
    assign mon_len   = mask_q[bit_idx] ? 5'(gtl_pkg::LUNAR_LONG_LEN)
                                       : 5'(gtl_pkg::LUNAR_SHORT_LEN);
    assign mon_len_w = DAYS_W'(mon_len);
    assign prev_mon  = mon_reg - 4'd1;

    assign greg_sum = days_reg + DAYS_W'(gd_reg);

    always_comb
    begin
        state_next     = state_reg;
        gy_next        = gy_reg;
        gm_next        = gm_reg;
        gd_next        = gd_reg;
        y_next         = y_reg;
        c100_next      = c100_reg;
        c400_next      = c400_reg;
        mo_next        = mo_reg;
        days_next      = days_reg;
        off_next       = off_reg;
        mon_next       = mon_reg;
        after_next     = after_reg;
        res_valid_next = res_valid_reg;
        res_year_next  = res_year_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        res_leap_next  = res_leap_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    gy_next        = in_year;
                    gm_next        = in_month;
                    gd_next        = in_day;
                    y_next         = FIRST_YEAR;
                    c100_next      = 7'(gtl_pkg::BASE_MOD100);
                    c400_next      = 9'(gtl_pkg::BASE_MOD400);
                    mo_next        = 4'd1;
                    days_next      = '0;
                    off_next       = '0;
                    mon_next       = 4'd1;
                    after_next     = 1'b0;
                    res_valid_next = 1'b0;
                    res_year_next  = '0;
                    res_month_next = '0;
                    res_day_next   = '0;
                    res_leap_next  = 1'b0;
                    state_next     = in_bad ? FINISH : GREG_YEAR;
                end
            end

            GREG_YEAR:
            begin
                if (y_reg == gy_reg)
                begin
                    state_next = GREG_MONTH;
                end
                else
                begin
                    days_next = days_reg + (y_leap ? DAYS_W'(gtl_pkg::GREG_LEAP_LEN)
                                                   : DAYS_W'(gtl_pkg::GREG_YEAR_LEN));
                    y_next    = y_reg + 12'd1;
                    c100_next = (c100_reg == 7'd99)  ? 7'd0 : c100_reg + 7'd1;
                    c400_next = (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                end
            end

            GREG_MONTH:
            begin
                if (mo_reg == gm_reg)
                begin
                    if (greg_sum < DAYS_W'(gtl_pkg::DAY_OFFSET + 1))
                    begin
                        state_next = FINISH;
                    end
                    else
                    begin
                        days_next  = greg_sum - DAYS_W'(gtl_pkg::DAY_OFFSET);
                        state_next = LUNAR_YEAR;
                    end
                end
                else
                begin
                    days_next = days_reg + DAYS_W'(gtl_pkg::greg_month_len(mo_reg))
                              + DAYS_W'((mo_reg == 4'd2) && y_leap);
                    mo_next   = mo_reg + 4'd1;
                end
            end

            LUNAR_YEAR:
            begin
                if (year_len_w >= days_reg)
                begin
                    state_next = LUNAR_MONTH;
                end
                else if (off_reg == LAST_OFF)
                begin
                    state_next = FINISH;
                end
                else
                begin
                    days_next = days_reg - year_len_w;
                    off_next  = off_reg + IDX_W'(1);
                end
            end

            LUNAR_MONTH:
            begin
                if (mon_len_w >= days_reg)
                begin
                    // second occurrence rule: months after the leap shift down by one
                    res_valid_next = 1'b1;
                    res_year_next  = FIRST_YEAR + 12'(off_reg);
                    res_month_next = after_reg ? prev_mon : mon_reg;
                    res_leap_next  = after_reg && (prev_mon == leap_nib);
                    res_day_next   = 5'(days_reg);
                    state_next     = FINISH;
                end
                else if (mon_reg == last_mon)
                begin
                    state_next = FINISH;
                end
                else
                begin
                    days_next = days_reg - mon_len_w;
                    if (leap_nib == mon_reg)
                    begin
                        after_next = 1'b1;
                    end
                    mon_next = mon_reg + 4'd1;
                end
            end

            FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, res_leap_reg, res_day_reg, res_month_reg,
                                      res_year_reg, res_valid_reg};
                    state_next     = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            off_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            off_reg       <= off_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        gy_reg        <= gy_next;
        gm_reg        <= gm_next;
        gd_reg        <= gd_next;
        y_reg         <= y_next;
        c100_reg      <= c100_next;
        c400_reg      <= c400_next;
        mo_reg        <= mo_next;
        days_reg      <= days_next;
        mon_reg       <= mon_next;
        after_reg     <= after_next;
        res_valid_reg <= res_valid_next;
        res_year_reg  <= res_year_next;
        res_month_reg <= res_month_next;
        res_day_reg   <= res_day_next;
        res_leap_reg  <= res_leap_next;
        out_data_reg  <= out_data_next;
    end

    // synchronous rom reads addressed by off_next, so the data lines up with off_reg
    always_ff @(posedge clk)
    begin
        mask_q      <= gtl_pkg::MASK_ROM[MASK_IDX_W'(off_next)];
        leap_byte_q <= gtl_pkg::LEAP_ROM[LEAP_IDX_W'(off_next >> 1)];
    end

endmodule

`default_nettype wire

// File: src/gtl_checker.sv
// port-level checks for the gregorian to lunar date converter, with its bind
`default_nettype none

module gtl_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tvalid,
    input wire logic                      s_axis_tready,
    input wire logic [gtl_pkg::IN_W-1:0]  s_axis_tdata,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [gtl_pkg::OUT_W-1:0] m_axis_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

    // one item in flight: no accept in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

    // a failed conversion carries all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[23:1] == 23'd0))
    else $error("invalid result with nonzero fields");

    // a good conversion has a legal month, day and year
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[16:13] != 4'd0) && (m_axis_tdata[16:13] <= 4'd12)
            && (m_axis_tdata[21:17] != 5'd0) && (m_axis_tdata[21:17] <= 5'd30)
            && (m_axis_tdata[12:1] >= 12'(gtl_pkg::BASE_YEAR)))
    else $error("valid result out of range");

endmodule

bind gregorian_to_lunar_date gtl_checker u_gtl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
